FILE: sv/cur_pkg.sv
// ----------------------------------------------------------------------------
// cur_pkg
// Types and constants shared by the chunked upload receiver.
// ----------------------------------------------------------------------------
package cur_pkg;

  localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;

  typedef enum logic [2:0] {
    REQ_ANNOUNCE = 3'd0,
    REQ_HEADER   = 3'd1,
    REQ_BODY     = 3'd2,
    REQ_TICK     = 3'd3,
    REQ_FINISH   = 3'd4,
    REQ_PSTART   = 3'd5,
    REQ_PSTOP    = 3'd6,
    REQ_QUERY    = 3'd7
  } req_t;

  typedef enum logic [4:0] {
    RSP_NONE         = 5'd0,
    RSP_READY        = 5'd1,
    RSP_REF_NAME     = 5'd2,
    RSP_REF_SIZE     = 5'd3,
    RSP_REF_PRINTING = 5'd4,
    RSP_REF_STORAGE  = 5'd5,
    RSP_NAK_LENGTH   = 5'd6,
    RSP_NAK_TIMEOUT  = 5'd7,
    RSP_NAK_NOSTREAM = 5'd8,
    RSP_NAK_ORDER    = 5'd9,
    RSP_NAK_CRC      = 5'd10,
    RSP_ACK          = 5'd11,
    RSP_REPORT       = 5'd12,
    RSP_ABORTED      = 5'd13,
    RSP_ABORT_REF    = 5'd14,
    RSP_DONE         = 5'd15,
    RSP_ND_NOSTREAM  = 5'd16,
    RSP_ND_SHORT     = 5'd17,
    RSP_ND_CRC       = 5'd18,
    RSP_READABLE     = 5'd19
  } rsp_t;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RECV = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  localparam logic [1:0] FM_REPORT = 2'd0;
  localparam logic [1:0] FM_ABORT  = 2'd1;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] file_size;
    logic [31:0] crc_value;
    logic [31:0] position;
    logic [15:0] chunk_len;
    logic [7:0]  body_byte;
    logic        name_ok;
    logic        storage_ok;
    logic        name_match;
    logic [1:0]  finish_mode;
  } req_item_t;

  typedef struct packed {
    logic [4:0]  resp_code;
    logic [31:0] echo_offset;
    logic [31:0] committed_bytes;
    logic [31:0] declared_bytes;
    logic [1:0]  stream_status;
    logic        printing_flag;
    logic [31:0] readable_bytes;
    logic        readable_unlimited;
    logic        file_completed;
  } rsp_item_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] reg_in,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = reg_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

FILE: sv/cur_core.sv
// ----------------------------------------------------------------------------
// cur_core
// Upload state and the per-request decision logic; one request per cycle while step is high.
// ----------------------------------------------------------------------------
module cur_core import cur_pkg::*; #(
  parameter int CHUNK_MAX = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  req_item_t   req,
  input  logic [15:0] timeout,
  output rsp_item_t   rsp
);

  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] size_r, size_nxt, crcd_r, crcd_nxt, comm_r, comm_nxt;
  logic [31:0] fcrc_r, fcrc_nxt, poff_r, poff_nxt, pcrc_r, pcrc_nxt;
  logic [15:0] plen_r, plen_nxt, nbody_r, nbody_nxt, silent_r, silent_nxt;
  logic [31:0] ccrc_r, ccrc_nxt, ftrial_r, ftrial_nxt;
  logic        active_r, active_nxt, gate_r, gate_nxt;

  logic [31:0] ccrc_upd, ftrial_upd, comm_sum;
  logic [15:0] nbody_inc, silent_inc;
  logic [32:0] end_pos;

  assign ccrc_upd   = crc_byte(ccrc_r, req.body_byte);
  assign ftrial_upd = crc_byte(ftrial_r, req.body_byte);
  assign nbody_inc  = nbody_r + 16'd1;
  assign silent_inc = (silent_r != 16'hFFFF) ? silent_r + 16'd1 : silent_r;
  assign end_pos    = {1'b0, poff_r} + {17'd0, plen_r};
  assign comm_sum   = comm_r + {16'd0, plen_r};

  always_comb begin
    phase_nxt = phase_r; size_nxt = size_r; crcd_nxt = crcd_r; comm_nxt = comm_r;
    fcrc_nxt = fcrc_r; poff_nxt = poff_r; pcrc_nxt = pcrc_r; plen_nxt = plen_r;
    nbody_nxt = nbody_r; silent_nxt = silent_r; ccrc_nxt = ccrc_r;
    ftrial_nxt = ftrial_r; active_nxt = active_r; gate_nxt = gate_r;
    rsp = '0;
    rsp.resp_code = RSP_NONE;
    unique case (req_t'(req.req_type))
      REQ_ANNOUNCE: begin
        if (!req.name_ok) rsp.resp_code = RSP_REF_NAME;
        else if (req.file_size == '0) rsp.resp_code = RSP_REF_SIZE;
        else if (phase_r == PH_RECV && req.file_size == size_r &&
                 req.crc_value == crcd_r && req.name_match) begin
          active_nxt = 1'b0;
          rsp.resp_code = RSP_READY;
        end else if (gate_r) rsp.resp_code = RSP_REF_PRINTING;
        else begin
          phase_nxt = PH_IDLE; size_nxt = '0; crcd_nxt = '0; comm_nxt = '0;
          active_nxt = 1'b0; gate_nxt = 1'b0;
          if (!req.storage_ok) rsp.resp_code = RSP_REF_STORAGE;
          else begin
            size_nxt = req.file_size; crcd_nxt = req.crc_value;
            fcrc_nxt = CRC_PRESET; phase_nxt = PH_RECV;
            rsp.resp_code = RSP_READY;
          end
        end
      end
      REQ_HEADER: begin
        poff_nxt = req.position;
        active_nxt = 1'b0;
        if (req.chunk_len == '0 || 32'(req.chunk_len) > 32'(CHUNK_MAX)) begin
          rsp.resp_code = RSP_NAK_LENGTH;
          rsp.echo_offset = req.position;
        end else begin
          plen_nxt = req.chunk_len; pcrc_nxt = req.crc_value;
          nbody_nxt = '0; silent_nxt = '0; ccrc_nxt = CRC_PRESET;
          ftrial_nxt = fcrc_r; active_nxt = 1'b1;
        end
      end
      REQ_BODY: begin
        if (active_r) begin
          ccrc_nxt = ccrc_upd; ftrial_nxt = ftrial_upd;
          nbody_nxt = nbody_inc; silent_nxt = '0;
          if (nbody_inc >= plen_r) begin
            active_nxt = 1'b0;
            rsp.echo_offset = poff_r;
            if (phase_r != PH_RECV) rsp.resp_code = RSP_NAK_NOSTREAM;
            else if (poff_r != comm_r || end_pos > {1'b0, size_r})
              rsp.resp_code = RSP_NAK_ORDER;
            else if (~ccrc_upd != pcrc_r) rsp.resp_code = RSP_NAK_CRC;
            else begin
              comm_nxt = comm_sum; fcrc_nxt = ftrial_upd;
              if (comm_sum == size_r) begin
                phase_nxt = PH_DONE;
                rsp.file_completed = 1'b1;
              end
              rsp.resp_code = RSP_ACK;
            end
          end
        end
      end
      REQ_TICK: begin
        if (active_r) begin
          silent_nxt = silent_inc;
          if (silent_inc >= timeout) begin
            active_nxt = 1'b0;
            rsp.resp_code = RSP_NAK_TIMEOUT;
            rsp.echo_offset = poff_r;
          end
        end
      end
      REQ_FINISH: begin
        if (req.finish_mode == FM_REPORT) rsp.resp_code = RSP_REPORT;
        else if (req.finish_mode == FM_ABORT) begin
          if (gate_r) rsp.resp_code = RSP_ABORT_REF;
          else begin
            phase_nxt = PH_IDLE; size_nxt = '0; crcd_nxt = '0; comm_nxt = '0;
            active_nxt = 1'b0; gate_nxt = 1'b0;
            rsp.resp_code = RSP_ABORTED;
          end
        end else if (phase_r == PH_IDLE) rsp.resp_code = RSP_ND_NOSTREAM;
        else if (comm_r != size_r) rsp.resp_code = RSP_ND_SHORT;
        else if (~fcrc_r != crcd_r) begin
          if (!gate_r) begin
            phase_nxt = PH_IDLE; size_nxt = '0; crcd_nxt = '0; comm_nxt = '0;
            active_nxt = 1'b0;
          end
          rsp.resp_code = RSP_ND_CRC;
        end else rsp.resp_code = RSP_DONE;
      end
      REQ_PSTART: gate_nxt = (phase_r != PH_IDLE) && req.name_match;
      REQ_PSTOP:  gate_nxt = 1'b0;
      REQ_QUERY: begin
        rsp.resp_code = RSP_READABLE;
        if (phase_r != PH_RECV) rsp.readable_unlimited = 1'b1;
        else if (req.position < comm_r) rsp.readable_bytes = comm_r - req.position;
      end
      default: ;
    endcase
    rsp.committed_bytes = comm_nxt;
    rsp.declared_bytes  = size_nxt;
    rsp.stream_status   = phase_nxt;
    rsp.printing_flag   = gate_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; size_r <= '0; crcd_r <= '0; comm_r <= '0;
      fcrc_r <= CRC_PRESET; poff_r <= '0; plen_r <= '0; pcrc_r <= '0;
      nbody_r <= '0; ccrc_r <= CRC_PRESET; ftrial_r <= CRC_PRESET;
      active_r <= 1'b0; gate_r <= 1'b0; silent_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt; size_r <= size_nxt; crcd_r <= crcd_nxt;
      comm_r <= comm_nxt; fcrc_r <= fcrc_nxt; poff_r <= poff_nxt;
      plen_r <= plen_nxt; pcrc_r <= pcrc_nxt; nbody_r <= nbody_nxt;
      ccrc_r <= ccrc_nxt; ftrial_r <= ftrial_nxt; active_r <= active_nxt;
      gate_r <= gate_nxt; silent_r <= silent_nxt;
    end
  end

endmodule

FILE: sv/chunked_upload_receiver.sv
// ----------------------------------------------------------------------------
// chunked_upload_receiver
// Resumable CRC-checked chunked upload receiver, stream interface.
// ----------------------------------------------------------------------------
// One request transfer in, one result transfer out. A request is registered,
// decided in the next cycle against the upload state and its result lands in
// a two-entry output buffer; a new request is taken every cycle while that
// buffer has room, so throughput is one request per cycle while results
// are taken. The byte-wide CRC update of each body byte sets the critical
// path. cfg_tdata sets the body timeout in ticks; write it only while idle.
module chunked_upload_receiver import cur_pkg::*; #(
  parameter int CHUNK_MAX = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_tdata,   // body_timeout_ticks
  input  logic         in_tvalid,
  output logic         in_tready,
  // req_type[2:0], file_size[34:3], crc_value[66:35], position[98:67],
  // chunk_len[114:99], body_byte[122:115], name_ok[123], storage_ok[124],
  // name_match[125], finish_mode[127:126]
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // resp_code[4:0], echo_offset[36:5], committed_bytes[68:37],
  // declared_bytes[100:69], stream_status[102:101], printing_flag[103],
  // readable_bytes[135:104], readable_unlimited[136], file_completed[137]
  output logic [143:0] out_tdata
);

  logic [15:0] tmo_r;
  req_item_t   req_r;
  logic        req_v_r;
  rsp_item_t   rsp;
  rsp_item_t   buf_r [2];
  logic [1:0]  cnt_r;
  logic        wp_r, rp_r;
  logic        push, pop;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) tmo_r <= 16'd2000;
    else if (cfg_valid) tmo_r <= cfg_tdata;
  end

  // in flight = registered request plus buffered results; keep total <= 2
  assign in_tready = ({1'b0, cnt_r} + {2'b0, req_v_r}) < 3'd2 ||
                     (pop && ({1'b0, cnt_r} + {2'b0, req_v_r}) < 3'd3);
  assign push = req_v_r;
  assign pop  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) req_v_r <= 1'b0;
    else req_v_r <= in_tvalid && in_tready;
    if (in_tvalid && in_tready) req_r <= req_item_t'({in_tdata[2:0], in_tdata[34:3],
      in_tdata[66:35], in_tdata[98:67], in_tdata[114:99], in_tdata[122:115],
      in_tdata[123], in_tdata[124], in_tdata[125], in_tdata[127:126]});
  end

  cur_core #(.CHUNK_MAX(CHUNK_MAX)) u_core (
    .clk(clk), .rst_n(rst_n), .step(req_v_r), .req(req_r), .timeout(tmo_r),
    .rsp(rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) buf_r[wp_r] <= rsp;
  end

  assign out_tvalid = cnt_r != 2'd0;
  always_comb begin
    out_tdata = '0;
    out_tdata[0 +: 5]    = buf_r[rp_r].resp_code;
    out_tdata[5 +: 32]   = buf_r[rp_r].echo_offset;
    out_tdata[37 +: 32]  = buf_r[rp_r].committed_bytes;
    out_tdata[69 +: 32]  = buf_r[rp_r].declared_bytes;
    out_tdata[101 +: 2]  = buf_r[rp_r].stream_status;
    out_tdata[103]       = buf_r[rp_r].printing_flag;
    out_tdata[104 +: 32] = buf_r[rp_r].readable_bytes;
    out_tdata[136]       = buf_r[rp_r].readable_unlimited;
    out_tdata[137]       = buf_r[rp_r].file_completed;
  end

endmodule

FILE: sv/cur_checker.sv
// ----------------------------------------------------------------------------
// cur_checker
// Port-level checks on the upload receiver, bound to the top level.
// ----------------------------------------------------------------------------
module cur_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [143:0] out_tdata
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // an accepted request yields a result after the request register and the output buffer
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> ##1 out_tvalid)
    else $error("missing result");

  // completion only rides on an ack
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[137] |-> out_tdata[4:0] == 5'd11)
    else $error("completion without ack");

  // echo offset is zero outside nak and ack codes
  a_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[4:0] < 5'd6 || out_tdata[4:0] > 5'd11)
    |-> out_tdata[36:5] == 32'd0)
    else $error("stray echo offset");

endmodule

bind chunked_upload_receiver cur_checker u_cur_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
